// ===== rtl/core/md5_pkg.sv =====
// Shared types, constants and functions for the MD5 digest block.
// Used by md5_ctrl, md5_dpath and the top level md5_message_digest.
// No dependencies.
package md5_pkg;

    // Source of the byte that is appended to the message block.
    localparam logic [1:0] BSEL_DATA = 2'd0;
    localparam logic [1:0] BSEL_MARK = 2'd1;
    localparam logic [1:0] BSEL_ZERO = 2'd2;
    localparam logic [1:0] BSEL_LEN  = 2'd3;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_START_POS = 6'd56;
    localparam logic [5:0] BLOCK_END_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;    // load the input word
        logic       put;        // append one byte at the fill position
        logic [1:0] bsel;       // which byte to append
        logic       load_work;  // copy the chaining value into the working set
        logic       round;      // perform one compression round
        logic [5:0] round_idx;  // round number, 0 to 63
        logic       finish;     // add the working set into the chaining value
        logic       chain_init; // return to the initial chaining value
        logic [1:0] out_idx;    // digest word shown on the output
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pos_end;   // the fill position is the final byte of the block
        logic pos_len;   // the fill position is where the length field starts
    } sts_t;

    function automatic logic [31:0] init_value(input logic [1:0] i);
        logic [31:0] v;
        unique case (i)
            2'd0:    v = 32'h67452301;
            2'd1:    v = 32'hefcdab89;
            2'd2:    v = 32'h98badcfe;
            default: v = 32'h10325476;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [3:0] i);
        logic [4:0] s;
        unique case (i)
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/md5_message_digest.sv =====
// Top level of the MD5 message digest block.
// Instantiates md5_ctrl and md5_dpath; depends on md5_pkg.
//
// Usage. The message arrives on the slave stream as 32-bit words, first byte
// in bits 7:0, each with a count of valid low-order bytes (0 to 4; a count of
// 5 to 7 is treated as 4). s_tlast marks the final word of the message. Each
// word accepted before the final one returns no result; the final word makes
// the block append the 0x80 marker, zero padding and the 64-bit bit length,
// and then present the four digest words A, B, C, D on the master stream,
// with the position of each word alongside and m_tlast on the fourth.
// Flow. The block handles one word at a time: it takes the word and then
// places its valid bytes one by one in the 64-byte block buffer. Each full
// block goes through 64 rounds, one round per cycle in the compression
// engine, and then a fold of the result into the chaining value. Padding
// after the final word places the padding bytes one by one, moves to the
// length field and takes one or two compressions.
// Reset restores the initial chaining value and clears the length count.
// While the receiver stalls, the current digest word holds steady and no new
// message word is accepted until all four digest words have been taken.
module md5_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] data_word, [34:32] valid_bytes, rest zero
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [33:32] word_index, rest zero
    output logic        m_tlast    // last_word
);
    import md5_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic [31:0] digest_word;

    md5_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_count (s_tdata[34:32]),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    md5_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_word     (s_tdata[31:0]),
        .cmd         (cmd),
        .sts         (sts),
        .digest_word (digest_word)
    );

    // The digest word comes straight from the chaining registers, which hold
    // still while the output waits.
    assign m_tdata = {6'b000000, cmd.out_idx, digest_word};

endmodule

// ===== rtl/core/md5_ctrl.sv =====
// Sequencer for the MD5 digest block: byte feeding, padding, rounds, output.
// Depends on md5_pkg; drives md5_dpath through cmd_t and reads sts_t.
module md5_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [2:0]      in_count,
    input  logic            s_tlast,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic            m_tlast,
    input  md5_pkg::sts_t   sts,
    output md5_pkg::cmd_t   cmd
);
    import md5_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DATA = 3'd1;
    localparam logic [2:0] ST_MARK = 3'd2;
    localparam logic [2:0] ST_ZERO = 3'd3;
    localparam logic [2:0] ST_LEN  = 3'd4;
    localparam logic [2:0] ST_COMP = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] ret_reg, ret_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       last_reg, last_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [1:0] idx_reg, idx_next;
    logic [2:0] clamped;
    logic [2:0] after;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            cnt_reg   <= 3'd0;
            last_reg  <= 1'b0;
            rnd_reg   <= 6'd0;
            idx_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        clamped    = (in_count > 3'd4) ? 3'd4 : in_count;
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        after      = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;
        cmd        = '0;
        cmd.round_idx = rnd_reg;
        cmd.out_idx   = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    cnt_next    = clamped;
                    last_next   = s_tlast;
                    if (clamped != 3'd0) begin
                        state_next = ST_DATA;
                    end else begin
                        state_next = s_tlast ? ST_MARK : ST_IDLE;
                    end
                end
            end
            ST_DATA, ST_MARK, ST_LEN: begin
                cmd.put = 1'b1;
                if (state_reg == ST_DATA) begin
                    cmd.bsel = BSEL_DATA;
                    cnt_next = cnt_reg - 3'd1;
                    if (cnt_reg == 3'd1) begin
                        after = last_reg ? ST_MARK : ST_IDLE;
                    end else begin
                        after = ST_DATA;
                    end
                end else if (state_reg == ST_MARK) begin
                    cmd.bsel = BSEL_MARK;
                    after    = ST_ZERO;
                end else begin
                    cmd.bsel = BSEL_LEN;
                    after    = ST_OUT;
                end
                if (sts.pos_end) begin
                    cmd.load_work = 1'b1;
                    ret_next      = after;
                    rnd_next      = 6'd0;
                    state_next    = ST_COMP;
                end else if (state_reg != ST_LEN) begin
                    state_next = after;
                end
            end
            ST_ZERO: begin
                if (sts.pos_len) begin
                    state_next = ST_LEN;
                end else begin
                    cmd.put  = 1'b1;
                    cmd.bsel = BSEL_ZERO;
                    if (sts.pos_end) begin
                        cmd.load_work = 1'b1;
                        ret_next      = ST_ZERO;
                        rnd_next      = 6'd0;
                        state_next    = ST_COMP;
                    end
                end
            end
            ST_COMP: begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                idx_next   = 2'd0;
                state_next = ret_reg;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                m_tlast  = (idx_reg == 2'd3);
                if (m_tready) begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        cmd.chain_init = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/md5_dpath.sv =====
// Datapath of the MD5 digest block: message block store, length and fill
// counters, one-round-per-cycle compression engine and chaining value.
// Depends on md5_pkg; controlled by md5_ctrl through cmd_t.
module md5_dpath (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [31:0]     in_word,
    input  md5_pkg::cmd_t   cmd,
    output md5_pkg::sts_t   sts,
    output logic [31:0]     digest_word
);
    import md5_pkg::*;

    logic [31:0] blk_reg [16];
    logic [31:0] chain_reg [4];
    logic [31:0] word_reg;
    logic [60:0] len_reg;
    logic [5:0]  pos_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;

    logic [63:0] len_bits;
    logic [7:0]  put_byte;
    logic [31:0] f;
    logic [3:0]  g;
    logic [3:0]  r4;
    logic [31:0] t_sum;
    logic [31:0] b_new;

    assign len_bits    = {len_reg, 3'b000};
    assign sts.pos_end = (pos_reg == BLOCK_END_POS);
    assign sts.pos_len = (pos_reg == LEN_START_POS);
    assign digest_word = chain_reg[cmd.out_idx];

    always_comb begin
        unique case (cmd.bsel)
            BSEL_DATA: put_byte = word_reg[7:0];
            BSEL_MARK: put_byte = PAD_MARK_BYTE;
            BSEL_ZERO: put_byte = 8'h00;
            default:   put_byte = len_bits[{pos_reg[2:0], 3'b000} +: 8];
        endcase
    end

    // Round function and message word schedule for the current round.
    always_comb begin
        r4 = cmd.round_idx[3:0];
        unique case (cmd.round_idx[5:4])
            2'd0: begin
                f = d_reg ^ (b_reg & (c_reg ^ d_reg));
                g = r4;
            end
            2'd1: begin
                f = c_reg ^ (d_reg & (b_reg ^ c_reg));
                g = r4 * 4'd5 + 4'd1;
            end
            2'd2: begin
                f = b_reg ^ c_reg ^ d_reg;
                g = r4 * 4'd3 + 4'd5;
            end
            default: begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = r4 * 4'd7;
            end
        endcase
        t_sum = a_reg + f + round_const(cmd.round_idx) + blk_reg[g];
        b_new = b_reg + rotl32(t_sum, rot_amount({cmd.round_idx[5:4], cmd.round_idx[1:0]}));
    end

    // Message block: no reset, every byte is written before a round reads it.
    always_ff @(posedge aclk) begin
        if (cmd.put) begin
            blk_reg[pos_reg[5:2]][{pos_reg[1:0], 3'b000} +: 8] <= put_byte;
        end
        if (cmd.capture) begin
            word_reg <= in_word;
        end else if (cmd.put && cmd.bsel == BSEL_DATA) begin
            word_reg <= word_reg >> 8;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_work) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end else if (cmd.round) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.chain_init) begin
            for (int i = 0; i < 4; i++) begin
                chain_reg[i] <= init_value(2'(i));
            end
            len_reg <= '0;
            pos_reg <= '0;
        end else begin
            if (cmd.finish) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
            if (cmd.put) begin
                pos_reg <= pos_reg + 6'd1;
                if (cmd.bsel == BSEL_DATA) begin
                    len_reg <= len_reg + 61'd1;
                end
            end
        end
    end

endmodule
